[sv/rfw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rfw_pkg;

  localparam int CoordBitsDef = 24;
  localparam int WgtW         = 24;
  localparam int ValW         = 40;
  localparam int CfgIdxW      = 4;
  localparam int CfgDataW     = 32;
  localparam int DvdW         = 57;
  localparam int PrdW         = 72;

  localparam logic [CfgIdxW-1:0] REG_CENTER_X    = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_CENTER_Y    = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_NEAR_RADIUS = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_FAR_RADIUS  = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_NEAR_WEIGHT = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_FAR_WEIGHT  = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_ADD_FACTOR  = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_MUL_FACTOR  = 4'd7;

  localparam logic [23:0] FarRadiusRst  = 24'd100000;
  localparam logic [23:0] NearWeightRst = 24'd32768;
  localparam logic [23:0] FarWeightRst  = 24'd65536;
  localparam logic [23:0] MulFactorRst  = 24'd65536;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQX,
    OP_SQY,
    OP_ROOT,
    OP_SEL,
    OP_MULD,
    OP_DIV,
    OP_INTERP,
    OP_MA,
    OP_MM,
    OP_ADD,
    OP_P1,
    OP_P2,
    OP_FIN
  } op_e;

  typedef struct packed {
    logic interp;
    logic mul_en;
  } stat_t;

  function automatic int root_bits(input int coord_bits);
    int rw;
    rw = 2 * (coord_bits + 1) + 1 + 16;
    rw = ((rw + 1) / 2) * 2;
    return rw / 2;
  endfunction

  function automatic logic [ValW-1:0] sat40(input logic signed [ValW+1:0] v);
    logic [ValW-1:0] r;
    if (v > $signed({3'b000, {(ValW-1){1'b1}}})) begin
      r = {1'b0, {(ValW-1){1'b1}}};
    end else if (v < $signed({3'b111, {(ValW-1){1'b0}}})) begin
      r = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      r = v[ValW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/rfw_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module rfw_ctrl #(
  parameter int COORD_BITS = rfw_pkg::CoordBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rfw_pkg::stat_t stat_i,
  output rfw_pkg::op_e       op_o
);

  localparam int Rt   = rfw_pkg::root_bits(COORD_BITS);
  localparam int MaxN = (Rt > rfw_pkg::DvdW) ? Rt : rfw_pkg::DvdW;
  localparam int CnW  = $clog2(MaxN + 1);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SQX    = 14'b00000000000010,
    S_SQY    = 14'b00000000000100,
    S_ROOT   = 14'b00000000001000,
    S_SEL    = 14'b00000000010000,
    S_MULD   = 14'b00000000100000,
    S_DIV    = 14'b00000001000000,
    S_INTERP = 14'b00000010000000,
    S_MA     = 14'b00000100000000,
    S_MM     = 14'b00001000000000,
    S_ADD    = 14'b00010000000000,
    S_P1     = 14'b00100000000000,
    S_P2     = 14'b01000000000000,
    S_FIN    = 14'b10000000000000
  } state_e;

  state_e         state_q, state_d;
  logic [CnW-1:0] cnt_q, cnt_d;
  logic           ovld_q, ovld_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovld_d  = ovld_q & ~out_ready_i;
    op_o    = rfw_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = rfw_pkg::OP_LOAD;
          state_d = S_SQX;
        end
      end
      S_SQX: begin
        op_o    = rfw_pkg::OP_SQX;
        state_d = S_SQY;
      end
      S_SQY: begin
        op_o    = rfw_pkg::OP_SQY;
        cnt_d   = '0;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        op_o  = rfw_pkg::OP_ROOT;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CnW'(Rt - 1)) begin
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        op_o    = rfw_pkg::OP_SEL;
        state_d = stat_i.interp ? S_MULD : S_MA;
      end
      S_MULD: begin
        op_o    = rfw_pkg::OP_MULD;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        op_o  = rfw_pkg::OP_DIV;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CnW'(rfw_pkg::DvdW - 1)) begin
          state_d = S_INTERP;
        end
      end
      S_INTERP: begin
        op_o    = rfw_pkg::OP_INTERP;
        state_d = S_MA;
      end
      S_MA: begin
        op_o    = rfw_pkg::OP_MA;
        state_d = S_MM;
      end
      S_MM: begin
        op_o    = rfw_pkg::OP_MM;
        state_d = S_ADD;
      end
      S_ADD: begin
        op_o    = rfw_pkg::OP_ADD;
        state_d = stat_i.mul_en ? S_P1 : S_FIN;
      end
      S_P1: begin
        op_o    = rfw_pkg::OP_P1;
        state_d = S_P2;
      end
      S_P2: begin
        op_o    = rfw_pkg::OP_P2;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!ovld_q || out_ready_i) begin
          op_o    = rfw_pkg::OP_FIN;
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule
`default_nettype wire

[sv/rfw_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module rfw_dp #(
  parameter int COORD_BITS = rfw_pkg::CoordBitsDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rfw_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire logic [rfw_pkg::CfgDataW-1:0]         cfg_data_i,
  input  wire logic signed [COORD_BITS-1:0]         pos_x_i,
  input  wire logic signed [COORD_BITS-1:0]         pos_y_i,
  input  wire logic                                 has_base_i,
  input  wire logic signed [rfw_pkg::ValW-1:0]      base_value_i,
  input  wire rfw_pkg::op_e                         op_i,
  output rfw_pkg::stat_t                            stat_o,
  output logic signed [rfw_pkg::ValW-1:0]           result_value_o,
  output logic signed [rfw_pkg::WgtW-1:0]           weight_ceiling_o
);

  localparam int Cb   = COORD_BITS;
  localparam int Ab   = Cb + 1;
  localparam int SqW  = 2 * Ab;
  localparam int SumW = SqW + 1;
  localparam int Rt   = rfw_pkg::root_bits(COORD_BITS);
  localparam int Rw   = 2 * Rt;
  localparam int Zw   = (Rt > 33) ? Rt : 33;
  localparam int Vw   = rfw_pkg::ValW;
  localparam int Ww   = rfw_pkg::WgtW;
  localparam int Dv   = rfw_pkg::DvdW;
  localparam int Pw   = rfw_pkg::PrdW;
  localparam int Hv   = Vw / 2;

  // configuration
  logic signed [Cb-1:0] cx_q, cy_q;
  logic [23:0]          near_q, far_q;
  logic signed [Ww-1:0] nw_q, fw_q, addf_q, mulf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      near_q <= '0;
      far_q  <= rfw_pkg::FarRadiusRst;
      nw_q   <= rfw_pkg::NearWeightRst;
      fw_q   <= rfw_pkg::FarWeightRst;
      addf_q <= '0;
      mulf_q <= rfw_pkg::MulFactorRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rfw_pkg::REG_CENTER_X:    cx_q   <= cfg_data_i[Cb-1:0];
        rfw_pkg::REG_CENTER_Y:    cy_q   <= cfg_data_i[Cb-1:0];
        rfw_pkg::REG_NEAR_RADIUS: near_q <= cfg_data_i[23:0];
        rfw_pkg::REG_FAR_RADIUS:  far_q  <= cfg_data_i[23:0];
        rfw_pkg::REG_NEAR_WEIGHT: nw_q   <= cfg_data_i[Ww-1:0];
        rfw_pkg::REG_FAR_WEIGHT:  fw_q   <= cfg_data_i[Ww-1:0];
        rfw_pkg::REG_ADD_FACTOR:  addf_q <= cfg_data_i[Ww-1:0];
        rfw_pkg::REG_MUL_FACTOR:  mulf_q <= cfg_data_i[Ww-1:0];
        default: ;
      endcase
    end
  end

  logic [Ww-1:0] peak_q;

  // payload
  logic [Ab-1:0]        adx_q, ady_q;
  logic                 hb_q;
  logic signed [Vw-1:0] base_q;
  logic [SqW-1:0]       sqx_q;
  logic [Rw-1:0]        rad_q;
  logic [Rt+2:0]        rem_q;
  logic [Rt-1:0]        root_q;
  logic [31:0]          t_q, dd_q;
  logic [Ww:0]          dmag_q;
  logic                 dneg_q;
  logic [Dv-1:0]        dvd_q;
  logic [32:0]          drem_q;
  logic signed [Ww-1:0] w_q;
  logic signed [32:0]   pa_q, pm_q;
  logic signed [Vw-1:0] v_q;
  logic [Pw-1:0]        acc_q;
  logic                 mulen_q;
  logic signed [Vw-1:0] res_q;
  logic signed [Ww-1:0] ceil_q;

  // coordinate deltas
  logic signed [Ab-1:0] dx, dy;
  assign dx = $signed({pos_x_i[Cb-1], pos_x_i}) - $signed({cx_q[Cb-1], cx_q});
  assign dy = $signed({pos_y_i[Cb-1], pos_y_i}) - $signed({cy_q[Cb-1], cy_q});

  logic [Ab-1:0]  sq_op;
  logic [SqW-1:0] sq;
  assign sq_op = (op_i == rfw_pkg::OP_SQX) ? adx_q : ady_q;
  assign sq    = sq_op * sq_op;

  // root step
  logic [Rt+2:0] rem_sh, trial;
  logic          rge;
  assign rem_sh = {rem_q[Rt:0], rad_q[Rw-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign rge    = (rem_sh >= trial);

  // weight selection
  logic [Zw-1:0] zx, n8, f8, tz;
  logic          zlo, zhi;
  logic signed [Ww:0] diff;
  assign zx   = Zw'(root_q);
  assign n8   = Zw'({near_q, 8'h00});
  assign f8   = Zw'({far_q, 8'h00});
  assign tz   = zx - n8;
  assign zlo  = (zx < n8);
  assign zhi  = (zx > f8);
  assign diff = $signed({fw_q[Ww-1], fw_q}) - $signed({nw_q[Ww-1], nw_q});

  // division step
  logic [32:0] dsh;
  logic        dge;
  assign dsh = {drem_q[31:0], dvd_q[Dv-1]};
  assign dge = (dsh >= {1'b0, dd_q});

  // weight times factor
  logic signed [Ww-1:0] fsel;
  logic [Ww-1:0]        wmag, fmag;
  logic [2*Ww-1:0]      wf;
  logic [32:0]          wfs;
  logic signed [32:0]   wf_r;
  assign fsel = (op_i == rfw_pkg::OP_MA) ? addf_q : mulf_q;
  assign wmag = w_q[Ww-1] ? Ww'(-w_q) : w_q;
  assign fmag = fsel[Ww-1] ? Ww'(-fsel) : fsel;
  assign wf   = wmag * fmag;
  assign wfs  = {1'b0, wf[2*Ww-1:16]};
  assign wf_r = (w_q[Ww-1] ^ fsel[Ww-1]) ? -$signed(wfs) : $signed(wfs);

  // value times product
  logic [Vw-1:0] vmag;
  logic [31:0]   pmag;
  logic [Hv-1:0] vpart;
  logic [Hv+31:0] vp;
  logic          vneg;
  assign vmag  = v_q[Vw-1] ? Vw'(-v_q) : v_q;
  assign pmag  = pm_q[32] ? 32'(-pm_q) : pm_q[31:0];
  assign vpart = (op_i == rfw_pkg::OP_P1) ? vmag[Hv-1:0] : vmag[Vw-1:Hv];
  assign vp    = vpart * pmag;
  assign vneg  = v_q[Vw-1] ^ pm_q[32];

  logic [Pw-17:0] am, alim, asat;
  logic [Vw-1:0]  mres;
  assign am   = acc_q[Pw-1:16];
  assign alim = vneg ? (Pw-16)'({1'b1, {(Vw-1){1'b0}}})
                     : (Pw-16)'({1'b0, {(Vw-1){1'b1}}});
  assign asat = (am > alim) ? alim : am;
  assign mres = vneg ? Vw'(-asat[Vw-1:0]) : asat[Vw-1:0];

  assign stat_o.interp = !zlo && !zhi && (f8 > n8);
  assign stat_o.mul_en = mulen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (op_i == rfw_pkg::OP_MA && $signed(w_q) > $signed(peak_q)) begin
      peak_q <= w_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      rfw_pkg::OP_LOAD: begin
        adx_q  <= dx[Ab-1] ? Ab'(-dx) : dx;
        ady_q  <= dy[Ab-1] ? Ab'(-dy) : dy;
        hb_q   <= has_base_i;
        base_q <= base_value_i;
      end
      rfw_pkg::OP_SQX: sqx_q <= sq;
      rfw_pkg::OP_SQY: begin
        rad_q  <= Rw'({SumW'(sqx_q) + SumW'(sq), 16'h0000});
        rem_q  <= '0;
        root_q <= '0;
      end
      rfw_pkg::OP_ROOT: begin
        rad_q  <= {rad_q[Rw-3:0], 2'b00};
        rem_q  <= rge ? rem_sh - trial : rem_sh;
        root_q <= {root_q[Rt-2:0], rge};
      end
      rfw_pkg::OP_SEL: begin
        w_q    <= zhi && !zlo ? fw_q : nw_q;
        t_q    <= tz[31:0];
        dd_q   <= 32'(f8 - n8);
        dmag_q <= diff[Ww] ? (Ww+1)'(-diff) : diff;
        dneg_q <= diff[Ww];
      end
      rfw_pkg::OP_MULD: begin
        dvd_q  <= Dv'(dmag_q * t_q);
        drem_q <= '0;
      end
      rfw_pkg::OP_DIV: begin
        drem_q <= dge ? dsh - {1'b0, dd_q} : dsh;
        dvd_q  <= {dvd_q[Dv-2:0], dge};
      end
      rfw_pkg::OP_INTERP: begin
        w_q <= dneg_q ? Ww'({nw_q[Ww-1], nw_q} - dvd_q[Ww:0])
                      : Ww'({nw_q[Ww-1], nw_q} + dvd_q[Ww:0]);
      end
      rfw_pkg::OP_MA: pa_q <= wf_r;
      rfw_pkg::OP_MM: begin
        pm_q    <= wf_r;
        mulen_q <= hb_q && (mulf_q != '0);
      end
      rfw_pkg::OP_ADD: begin
        if (hb_q) begin
          v_q <= (addf_q != '0)
                 ? rfw_pkg::sat40((Vw+2)'(base_q) + (Vw+2)'(pa_q)) : base_q;
        end else begin
          v_q <= rfw_pkg::sat40((Vw+2)'(pm_q) + (Vw+2)'(pa_q));
        end
      end
      rfw_pkg::OP_P1: acc_q <= Pw'(vp);
      rfw_pkg::OP_P2: acc_q <= acc_q + Pw'({vp, Hv'(0)});
      rfw_pkg::OP_FIN: begin
        res_q  <= mulen_q ? mres : v_q;
        ceil_q <= peak_q;
      end
      default: ;
    endcase
  end

  assign result_value_o   = res_q;
  assign weight_ceiling_o = ceil_q;

endmodule
`default_nettype wire

[sv/radial_falloff_weight.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  beat contents
// cfg      in         cfg_index_i, cfg_data_i
// in       in         pos_x_i, pos_y_i, has_base_i, base_value_i
// out      out        result_value_o, weight_ceiling_o
// one item at a time: a bit-serial square root of R steps (R = COORD_BITS + 10, 34 at default),
// then a restoring divider when the point lies between the radii, then the combine steps,
// then the value-times-product steps when the multiply term applies to a base value
// the bit-serial square root and restoring divider set the cycle count
// reset loads the register defaults and clears the running weight peak behind the weight ceiling
// a finished beat waits in the output register while the next item is taken
module radial_falloff_weight #(
  parameter int COORD_BITS = rfw_pkg::CoordBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [rfw_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [rfw_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [COORD_BITS-1:0]    pos_x_i,
  input  wire logic signed [COORD_BITS-1:0]    pos_y_i,
  input  wire logic                            has_base_i,
  input  wire logic signed [rfw_pkg::ValW-1:0] base_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [rfw_pkg::ValW-1:0]      result_value_o,
  output logic signed [rfw_pkg::WgtW-1:0]      weight_ceiling_o
);

  rfw_pkg::op_e   op;
  rfw_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  rfw_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .op_o       (op)
  );

  rfw_dp #(
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .has_base_i      (has_base_i),
    .base_value_i    (base_value_i),
    .op_i            (op),
    .stat_o          (stat),
    .result_value_o  (result_value_o),
    .weight_ceiling_o(weight_ceiling_o)
  );

endmodule
`default_nettype wire
